// ----- hdl/aabb_affine_transform_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the transformed bounding box unit
// Concurrent assertion wrappers clocked on i_clk, removed in synthesis.
// ----------------------------------------------------------------------------
`ifndef AABB_AFFINE_TRANSFORM_UNIT_MACROS_SVH
`define AABB_AFFINE_TRANSFORM_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define AATU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define AATU_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");
`else
`define AATU_ASSERT(lbl, prop)
`define AATU_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- hdl/aatu_pkg.sv -----
// ----------------------------------------------------------------------------
// Transformed bounding box package
// Widths, register codes and arithmetic helpers of the bounding box unit.
// ----------------------------------------------------------------------------
package aatu_pkg;

    localparam int FIELD_W   = 24;
    localparam int OUT_W     = 32;
    localparam int PROD_W    = 2 * FIELD_W;
    localparam int PSUM_W    = PROD_W + 1;
    localparam int ACC_W     = PROD_W + 2;
    localparam int QUOT_W    = ACC_W - 16;
    localparam int NUM_AXES  = 3;
    localparam int NUM_COEF  = 4;
    localparam int NUM_IN    = NUM_AXES * NUM_COEF;
    localparam int IN_W      = NUM_IN * FIELD_W;
    localparam int NUM_OUT   = 2 * NUM_AXES;
    localparam int OUT_DW    = NUM_OUT * OUT_W;
    localparam int NUM_STAGE = 5;
    localparam int ADDR_W    = 5;

    typedef enum logic [2:0] {
        REG_BOX_MIN_X = 3'd0,
        REG_BOX_MIN_Y = 3'd1,
        REG_BOX_MIN_Z = 3'd2,
        REG_BOX_MAX_X = 3'd3,
        REG_BOX_MAX_Y = 3'd4,
        REG_BOX_MAX_Z = 3'd5
    } t_reg_idx;

    typedef logic signed [FIELD_W-1:0] t_field;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [PSUM_W-1:0]  t_psum;
    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic signed [OUT_W-1:0]   t_out;

    function automatic t_prod mul_field(input t_field a, input t_field b);
        t_prod ax;
        t_prod bx;
        ax = {{FIELD_W{a[FIELD_W-1]}}, a};
        bx = {{FIELD_W{b[FIELD_W-1]}}, b};
        return ax * bx;
    endfunction

    // Floors Q18.32 to Q16.16, saturating; the caller adds the half.
    function automatic t_out round_sat(input t_acc acc);
        logic signed [QUOT_W-1:0] q;
        q = QUOT_W'(acc >>> 16);
        if (q > QUOT_W'(signed'(OUT_W'({1'b0, {(OUT_W-1){1'b1}}})))) begin
            return {1'b0, {(OUT_W-1){1'b1}}};
        end else if (q < $signed({{(QUOT_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}})) begin
            return {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            return q[OUT_W-1:0];
        end
    endfunction

endpackage

// ----- hdl/aabb_affine_transform_unit.sv -----
// ----------------------------------------------------------------------------
// Transformed axis-aligned bounding box unit
// Transforms a local box by an affine matrix and returns its world bounds.
// ----------------------------------------------------------------------------
// The unit takes one matrix request per cycle and returns one transformed
// box per cycle, as long as i_m_tready does not stall the output register.
// The pipeline has five register stages: eighteen 24x24 products,
// per-term minimum and maximum selection, two adder stages, and rounding
// with saturation into the output register. Each axis bound is the
// translation plus the sum of the smaller (or larger) of the coefficient
// times the box minimum and maximum, which equals the extreme over all eight
// corners. The box registers must be written only while the unit is empty.
`include "aabb_affine_transform_unit_macros.svh"

module aabb_affine_transform_unit
    import aatu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // Fields from bit 0 up: row0_col0, row0_col1, row0_col2, row0_shift,
    // row1_col0, row1_col1, row1_col2, row1_shift, row2_col0, row2_col1,
    // row2_col2, row2_shift; 24 bits each.
    input  logic [IN_W-1:0]   i_s_tdata,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // Fields from bit 0 up: out_min_x, out_min_y, out_min_z, out_max_x,
    // out_max_y, out_max_z; 32 bits each.
    output logic [OUT_DW-1:0] o_m_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_field r_box_min [NUM_AXES];
    t_field r_box_max [NUM_AXES];

    logic [NUM_STAGE-1:0] r_vld;
    logic [NUM_STAGE:0]   adv;

    t_prod  r_prod_lo [NUM_AXES][NUM_AXES];
    t_prod  r_prod_hi [NUM_AXES][NUM_AXES];
    t_field r_shift1  [NUM_AXES];
    t_prod  r_sel_lo  [NUM_AXES][NUM_AXES];
    t_prod  r_sel_hi  [NUM_AXES][NUM_AXES];
    t_field r_shift2  [NUM_AXES];
    t_psum  r_pa_lo   [NUM_AXES];
    t_psum  r_pb_lo   [NUM_AXES];
    t_psum  r_pa_hi   [NUM_AXES];
    t_psum  r_pb_hi   [NUM_AXES];
    t_acc   r_acc_lo  [NUM_AXES];
    t_acc   r_acc_hi  [NUM_AXES];
    t_out   r_out_lo  [NUM_AXES];
    t_out   r_out_hi  [NUM_AXES];

    t_prod  n_prod_lo [NUM_AXES][NUM_AXES];
    t_prod  n_prod_hi [NUM_AXES][NUM_AXES];
    t_field n_shift1  [NUM_AXES];
    t_prod  n_sel_lo  [NUM_AXES][NUM_AXES];
    t_prod  n_sel_hi  [NUM_AXES][NUM_AXES];
    t_psum  n_pa_lo   [NUM_AXES];
    t_psum  n_pb_lo   [NUM_AXES];
    t_psum  n_pa_hi   [NUM_AXES];
    t_psum  n_pb_hi   [NUM_AXES];
    t_acc   n_acc_lo  [NUM_AXES];
    t_acc   n_acc_hi  [NUM_AXES];
    t_out   n_out_lo  [NUM_AXES];
    t_out   n_out_hi  [NUM_AXES];

    logic     cfg_wr;
    t_reg_idx cfg_idx;
    t_field   rd_val;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_box_min[a] <= '0;
                r_box_max[a] <= '0;
            end
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_BOX_MIN_X: r_box_min[0] <= pwdata[FIELD_W-1:0];
                REG_BOX_MIN_Y: r_box_min[1] <= pwdata[FIELD_W-1:0];
                REG_BOX_MIN_Z: r_box_min[2] <= pwdata[FIELD_W-1:0];
                REG_BOX_MAX_X: r_box_max[0] <= pwdata[FIELD_W-1:0];
                REG_BOX_MAX_Y: r_box_max[1] <= pwdata[FIELD_W-1:0];
                REG_BOX_MAX_Z: r_box_max[2] <= pwdata[FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_BOX_MIN_X: rd_val = r_box_min[0];
            REG_BOX_MIN_Y: rd_val = r_box_min[1];
            REG_BOX_MIN_Z: rd_val = r_box_min[2];
            REG_BOX_MAX_X: rd_val = r_box_max[0];
            REG_BOX_MAX_Y: rd_val = r_box_max[1];
            REG_BOX_MAX_Z: rd_val = r_box_max[2];
            default:       rd_val = '0;
        endcase
    end

    assign prdata = {{(32-FIELD_W){rd_val[FIELD_W-1]}}, rd_val};

    // A stage takes new data when it is empty or its successor moves on.
    always_comb begin
        adv[NUM_STAGE] = i_m_tready;
        for (int k = NUM_STAGE - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_s_tready = adv[0];
    assign o_m_tvalid = r_vld[NUM_STAGE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGE; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= (k == 0) ? i_s_tvalid : r_vld[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_AXES; r++) begin
            for (int c = 0; c < NUM_AXES; c++) begin
                n_prod_lo[r][c] = mul_field(
                    i_s_tdata[(r*NUM_COEF+c)*FIELD_W +: FIELD_W], r_box_min[c]);
                n_prod_hi[r][c] = mul_field(
                    i_s_tdata[(r*NUM_COEF+c)*FIELD_W +: FIELD_W], r_box_max[c]);
                if (r_prod_lo[r][c] < r_prod_hi[r][c]) begin
                    n_sel_lo[r][c] = r_prod_lo[r][c];
                    n_sel_hi[r][c] = r_prod_hi[r][c];
                end else begin
                    n_sel_lo[r][c] = r_prod_hi[r][c];
                    n_sel_hi[r][c] = r_prod_lo[r][c];
                end
            end
            n_shift1[r] = i_s_tdata[(r*NUM_COEF+NUM_AXES)*FIELD_W +: FIELD_W];
            n_pa_lo[r] = PSUM_W'(r_sel_lo[r][0]) + PSUM_W'(r_sel_lo[r][1]);
            n_pa_hi[r] = PSUM_W'(r_sel_hi[r][0]) + PSUM_W'(r_sel_hi[r][1]);
            // The translation is widened to Q17.32 and the rounding half is added here.
            n_pb_lo[r] = PSUM_W'(r_sel_lo[r][2])
                       + PSUM_W'(signed'({r_shift2[r], 16'h0000}))
                       + PSUM_W'(32'sd32768);
            n_pb_hi[r] = PSUM_W'(r_sel_hi[r][2])
                       + PSUM_W'(signed'({r_shift2[r], 16'h0000}))
                       + PSUM_W'(32'sd32768);
            n_acc_lo[r] = ACC_W'(r_pa_lo[r]) + ACC_W'(r_pb_lo[r]);
            n_acc_hi[r] = ACC_W'(r_pa_hi[r]) + ACC_W'(r_pb_hi[r]);
            n_out_lo[r] = round_sat(r_acc_lo[r]);
            n_out_hi[r] = round_sat(r_acc_hi[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_prod_lo <= n_prod_lo;
            r_prod_hi <= n_prod_hi;
            r_shift1  <= n_shift1;
        end
        if (adv[1]) begin
            r_sel_lo <= n_sel_lo;
            r_sel_hi <= n_sel_hi;
            r_shift2 <= r_shift1;
        end
        if (adv[2]) begin
            r_pa_lo <= n_pa_lo;
            r_pb_lo <= n_pb_lo;
            r_pa_hi <= n_pa_hi;
            r_pb_hi <= n_pb_hi;
        end
        if (adv[3]) begin
            r_acc_lo <= n_acc_lo;
            r_acc_hi <= n_acc_hi;
        end
        if (adv[4]) begin
            r_out_lo <= n_out_lo;
            r_out_hi <= n_out_hi;
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_AXES; r++) begin
            o_m_tdata[r*OUT_W +: OUT_W]            = r_out_lo[r];
            o_m_tdata[(NUM_AXES+r)*OUT_W +: OUT_W] = r_out_hi[r];
        end
    end

    `AATU_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_m_tvalid)
    `AATU_ASSERT(a_full_stall, (&r_vld && !i_m_tready) |-> !o_s_tready)
    `AATU_ASSERT(a_min_le_max, o_m_tvalid |-> (r_out_lo[0] <= r_out_hi[0] && r_out_lo[1] <= r_out_hi[1] && r_out_lo[2] <= r_out_hi[2]))

endmodule

// ----- tb/sv/tb_aabb_affine_transform_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the transformed bounding box unit
// Programs local box bounds over the register port, streams affine matrices
// into the unit and compares every returned world box, field by field, with
// bounds predicted from all eight transformed corners of the local box.
// ----------------------------------------------------------------------------
module tb_aabb_affine_transform_unit;
    import aatu_pkg::*;

    localparam int     NUM_BOX_REGS = 6;
    localparam t_field F_MAX        = 24'h7FFFFF;
    localparam t_field F_MIN        = 24'h800000;
    localparam t_field ONE          = 24'h010000;
    localparam t_field NEG_ONE      = 24'hFF0000;
    localparam t_field HALF         = 24'h008000;
    localparam t_field NEG_HALF     = 24'hFF8000;
    localparam longint SAT_HI       = 64'sd2147483647;
    localparam longint SAT_LO       = -64'sd2147483648;

    class box_bounds_board;
        t_field            bound [NUM_BOX_REGS];
        logic [OUT_DW-1:0] pending_bounds [$];
        int                mismatches;
        int                results_checked;
        int                requests_seen;
        string             field_names [NUM_OUT] = '{"out_min_x", "out_min_y", "out_min_z",
                                                     "out_max_x", "out_max_y", "out_max_z"};

        function new();
            foreach (bound[i]) bound[i] = '0;
            mismatches      = 0;
            results_checked = 0;
            requests_seen   = 0;
        endfunction

        function void load_bound(int idx, t_field v);
            if (idx < NUM_BOX_REGS) bound[idx] = v;
        endfunction

        function logic [OUT_DW-1:0] transform_box(logic [IN_W-1:0] m);
            t_field            f;
            longint            coef [NUM_AXES][NUM_COEF];
            longint            corner [NUM_AXES];
            longint            lo [NUM_AXES];
            longint            hi [NUM_AXES];
            longint            acc;
            longint            v;
            logic [OUT_DW-1:0] res;
            for (int r = 0; r < NUM_AXES; r++) begin
                for (int c = 0; c < NUM_COEF; c++) begin
                    f = m[(r*NUM_COEF+c)*FIELD_W +: FIELD_W];
                    coef[r][c] = f;
                end
            end
            for (int k = 0; k < 8; k++) begin
                corner[0] = k[2] ? bound[REG_BOX_MAX_X] : bound[REG_BOX_MIN_X];
                corner[1] = k[1] ? bound[REG_BOX_MAX_Y] : bound[REG_BOX_MIN_Y];
                corner[2] = k[0] ? bound[REG_BOX_MAX_Z] : bound[REG_BOX_MIN_Z];
                for (int r = 0; r < NUM_AXES; r++) begin
                    acc = coef[r][0] * corner[0] + coef[r][1] * corner[1]
                        + coef[r][2] * corner[2] + coef[r][3] * 64'sd65536;
                    v = (acc + 64'sd32768) >>> 16;
                    if (v > SAT_HI) v = SAT_HI;
                    if (v < SAT_LO) v = SAT_LO;
                    if (k == 0 || v < lo[r]) lo[r] = v;
                    if (k == 0 || v > hi[r]) hi[r] = v;
                end
            end
            for (int r = 0; r < NUM_AXES; r++) begin
                res[r*OUT_W +: OUT_W]            = lo[r][OUT_W-1:0];
                res[(NUM_AXES+r)*OUT_W +: OUT_W] = hi[r][OUT_W-1:0];
            end
            return res;
        endfunction

        function void note_matrix(logic [IN_W-1:0] m);
            pending_bounds = {pending_bounds, transform_box(m)};
            requests_seen++;
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40) $display("MISMATCH: %s", msg);
        endtask

        task check_bounds(logic [OUT_DW-1:0] got);
            logic [OUT_DW-1:0] want;
            if (pending_bounds.size() == 0) begin
                report($sformatf("result %h arrived with no request pending", got));
                return;
            end
            want = pending_bounds.pop_front();
            results_checked++;
            for (int i = 0; i < NUM_OUT; i++) begin
                if (got[i*OUT_W +: OUT_W] !== want[i*OUT_W +: OUT_W])
                    report($sformatf("result %0d %s got %h expected %h", results_checked,
                                     field_names[i], got[i*OUT_W +: OUT_W],
                                     want[i*OUT_W +: OUT_W]));
            end
        endtask

        task check_leftover();
            if (pending_bounds.size() != 0)
                report($sformatf("%0d results never arrived", pending_bounds.size()));
        endtask
    endclass

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic [IN_W-1:0]   i_s_tdata  = '0;
    logic              i_m_tready = 1'b0;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [ADDR_W-1:0] paddr      = '0;
    logic [31:0]       pwdata     = '0;
    logic              o_s_tready;
    logic              o_m_tvalid;
    logic [OUT_DW-1:0] o_m_tdata;
    logic [31:0]       prdata;
    logic              pready;

    box_bounds_board sb = new();
    bit              tx_calm = 1'b0;
    bit              rx_calm = 1'b0;
    int              rx_busy = 0;
    int              box_settings = 0;

    aabb_affine_transform_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_matrix(i_s_tdata);
            if (o_m_tvalid && i_m_tready) sb.check_bounds(o_m_tdata);
        end
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_busy > 0) begin
                i_m_tready <= 1'b0;
                rx_busy--;
            end else begin
                i_m_tready <= 1'b1;
                if (!rx_calm) begin
                    case ($urandom_range(0, 99)) inside
                        [0:1]:   rx_busy = $urandom_range(15, 60);
                        [2:24]:  rx_busy = $urandom_range(1, 3);
                        default: rx_busy = 0;
                    endcase
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("[aabb_affine_transform_unit] ERROR");
        $finish;
    end

    function automatic int pick_gap();
        if (tx_calm) return 0;
        case ($urandom_range(0, 99)) inside
            [0:59]:  return 0;
            [60:95]: return $urandom_range(1, 3);
            default: return $urandom_range(10, 40);
        endcase
    endfunction

    function automatic t_field rand_coef();
        case ($urandom_range(0, 9))
            0:       return F_MAX;
            1:       return F_MIN;
            2:       return '0;
            3, 4:    return t_field'($urandom_range(0, 262143)) - t_field'(131072);
            5:       return $urandom_range(0, 1) ? ONE : NEG_ONE;
            default: return t_field'($urandom);
        endcase
    endfunction

    function automatic t_field rand_bound();
        case ($urandom_range(0, 7))
            0:       return F_MAX;
            1:       return F_MIN;
            2:       return '0;
            3, 4:    return t_field'($urandom_range(0, 65535)) - t_field'(32768);
            default: return t_field'($urandom);
        endcase
    endfunction

    task automatic send_matrix(input logic [IN_W-1:0] d);
        int gap;
        gap = pick_gap();
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= IN_W'({(IN_W / 32 + 1){$urandom}});
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_fields(input t_field f [NUM_IN]);
        logic [IN_W-1:0] d;
        for (int i = 0; i < NUM_IN; i++) d[i*FIELD_W +: FIELD_W] = f[i];
        send_matrix(d);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending_bounds.size() != 0) @(negedge i_clk);
    endtask

    task automatic apb_write(input int idx, input t_field v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= {{8{v[FIELD_W-1]}}, v};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.load_bound(idx, v);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_box(input t_field mnx, input t_field mny, input t_field mnz,
                           input t_field mxx, input t_field mxy, input t_field mxz);
        wait_drained();
        apb_write(REG_BOX_MIN_X, mnx);
        apb_write(REG_BOX_MIN_Y, mny);
        apb_write(REG_BOX_MIN_Z, mnz);
        apb_write(REG_BOX_MAX_X, mxx);
        apb_write(REG_BOX_MAX_Y, mxy);
        apb_write(REG_BOX_MAX_Z, mxz);
        box_settings++;
    endtask

    initial begin
        t_field f [NUM_IN];

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // With the reset box every corner sits at the origin.
        f = '{F_MAX, F_MIN, ONE, F_MAX, ONE, 0, F_MIN, F_MIN, 0, F_MAX, ONE, 24'h000123};
        send_fields(f);
        f = '{F_MIN, F_MAX, 0, F_MIN, F_MAX, F_MIN, ONE, F_MAX, ONE, ONE, ONE, NEG_ONE};
        send_fields(f);
        wait_drained();
        apb_write(NUM_BOX_REGS, rand_bound());
        apb_write(NUM_BOX_REGS + 1, F_MAX);
        f = '{ONE, 0, 0, 24'h000777, 0, ONE, 0, 24'hFFF001, 0, 0, ONE, 0};
        send_fields(f);

        // Odd bounds with z minimum above its maximum.
        set_box(-2561, -1283, 515, 5121, 1795, -257);
        f = '{ONE, 0, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0};
        send_fields(f);
        f = '{ONE, 0, 0, 100, 0, ONE, 0, -100, 0, 0, ONE, F_MAX};
        send_fields(f);
        f = '{NEG_ONE, 0, 0, 0, 0, NEG_ONE, 0, 0, 0, 0, NEG_ONE, F_MIN};
        send_fields(f);
        f = '{HALF, 0, 0, 0, 0, HALF, 0, 0, 0, 0, HALF, 0};
        send_fields(f);
        f = '{NEG_HALF, 0, 0, 0, 0, NEG_HALF, 0, 0, 0, 0, NEG_HALF, 0};
        send_fields(f);
        f = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_fields(f);
        f = '{0, 0, ONE, 5, ONE, 0, 0, -5, 0, NEG_ONE, 0, 3};
        send_fields(f);
        f = '{F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX};
        send_fields(f);
        f = '{F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN};
        send_fields(f);

        // Full-range box, with matrices that drive the axes into saturation and an identity matrix with extreme shifts.
        set_box(F_MIN, F_MIN, F_MIN, F_MAX, F_MAX, F_MAX);
        f = '{F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX};
        send_fields(f);
        f = '{F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN};
        send_fields(f);
        f = '{F_MAX, F_MIN, F_MAX, F_MAX, F_MIN, F_MAX, F_MIN, F_MIN, F_MAX, F_MAX, F_MIN, 0};
        send_fields(f);
        f = '{ONE, 0, 0, 0, 0, ONE, 0, F_MAX, 0, 0, ONE, F_MIN};
        send_fields(f);

        // Swapped full-range box.
        set_box(F_MAX, F_MAX, F_MAX, F_MIN, F_MIN, F_MIN);
        f = '{F_MAX, F_MAX, F_MAX, F_MIN, F_MAX, F_MAX, F_MAX, F_MIN, F_MAX, F_MAX, F_MAX, F_MIN};
        send_fields(f);
        f = '{ONE, 0, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0};
        send_fields(f);

        // Tiny box and tiny coefficients exercise rounding around zero.
        set_box(1, -1, 128, -1, 1, -128);
        f = '{1, -1, 1, 0, -1, 1, -1, 0, HALF, NEG_HALF, 1, -1};
        send_fields(f);
        f = '{HALF, HALF, 0, 0, NEG_HALF, 0, HALF, 0, 0, NEG_HALF, NEG_HALF, 1};
        send_fields(f);

        for (int phase = 0; phase < 6; phase++) begin
            wait_drained();
            if ($urandom_range(0, 1)) apb_write(NUM_BOX_REGS + $urandom_range(0, 1), rand_bound());
            set_box(rand_bound(), rand_bound(), rand_bound(),
                    rand_bound(), rand_bound(), rand_bound());
            for (int n = 0; n < 205; n++) begin
                if (n % 64 == 0) begin
                    tx_calm = (phase == 0) || ($urandom_range(0, 3) == 0);
                    rx_calm = (phase == 0) || ($urandom_range(0, 3) == 0);
                end
                if ($urandom_range(0, 149) == 0) wait_drained();
                for (int i = 0; i < NUM_IN; i++)
                    f[i] = (i % NUM_COEF == NUM_COEF - 1) ? rand_bound() : rand_coef();
                send_fields(f);
            end
        end

        wait_drained();
        repeat (NUM_STAGE + 4) @(posedge i_clk);
        sb.check_leftover();

        $display("Summary: %0d matrix requests over %0d box settings, %0d world boxes compared.",
                 sb.requests_seen, box_settings + 1, sb.results_checked);
        if (sb.mismatches == 0) begin
            $display("[aabb_affine_transform_unit] OK");
        end else begin
            $display("[aabb_affine_transform_unit] ERROR");
        end
        $finish;
    end

endmodule
